// ----- rtl/brm_pkg.sv -----
// Package for the radix-2 Booth multiplier: operand widths, the per-cell
// state struct and the combinational Booth step. No dependencies.
`timescale 1ns / 1ps

package brm_pkg;

  localparam int unsigned Width   = 8;
  localparam int unsigned InW     = 8;
  localparam int unsigned ProdW   = 16;
  localparam int unsigned AccW    = Width + 1;
  localparam int unsigned FullW   = 2 * Width + 1;

  localparam logic [1:0] PairSub = 2'b10;
  localparam logic [1:0] PairAdd = 2'b01;

  typedef struct packed {
    logic [AccW-1:0]  acc;
    logic [Width-1:0] q;
    logic             prev;
    logic [AccW-1:0]  mcand;
  } step_t;

  function automatic step_t load_step(logic signed [InW-1:0] mcand,
                                      logic signed [InW-1:0] mplier);
    step_t s;
    s.acc   = '0;
    s.q     = Width'(mplier);
    s.prev  = 1'b0;
    s.mcand = AccW'(mcand);
    return s;
  endfunction

  function automatic step_t booth_step(step_t s);
    step_t           r;
    logic [AccW-1:0] sum;
    case ({s.q[0], s.prev})
      PairSub: sum = s.acc - s.mcand;
      PairAdd: sum = s.acc + s.mcand;
      default: sum = s.acc;
    endcase
    r.prev  = s.q[0];
    r.q     = {sum[0], s.q[Width-1:1]};
    r.acc   = {sum[AccW-1], sum[AccW-1:1]};
    r.mcand = s.mcand;
    return r;
  endfunction

  function automatic logic [ProdW-1:0] get_product(step_t s);
    logic [FullW-1:0] full;
    full = {s.acc, s.q};
    return ProdW'(full);
  endfunction

endpackage

// ----- rtl/brm_cell.sv -----
// One Booth step cell: registers the state after one add/subtract and shift.
// Depends on brm_pkg.
`timescale 1ns / 1ps

module brm_cell
  import brm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  step_t state_i,
  output logic  stall_o,
  output logic  valid_o,
  output step_t state_o,
  input  logic  stall_i
);

  logic  valid_q;
  step_t state_q;
  step_t state_d;

  assign stall_o = valid_q & stall_i;
  assign state_d = booth_step(state_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      state_q <= state_d;
    end
  end

  assign valid_o = valid_q;
  assign state_o = state_q;

endmodule

// ----- rtl/booth_radix2_multiplier_core.sv -----
// Radix-2 Booth signed multiplier: a row of Width step cells.
// Depends on brm_pkg and brm_cell.
//
// Usage:
//   Input channel carries a signed 8-bit multiplicand and multiplier; a beat
//   is taken when in_valid_i is high and in_stall_o is low.
//   Output channel carries the signed 16-bit product; a beat is taken when
//   out_valid_o is high and out_stall_i is low.
//   Each cell performs one Booth step and registers the result, so a beat
//   passes through all Width (8) cell registers in order before it leaves.
//   When nothing stalls, one beat enters per cycle; throughput is one product per cycle.
//   The last cell's register is the output register. When the receiver
//   stalls, the stall travels back only through occupied cells, so empty
//   cells keep absorbing new beats until the row is full; then in_stall_o
//   rises. Payloads hold steady while stalled.
//   Reset (rst_ni low, asynchronous) empties every cell; no item state
//   survives it. There is no configuration.
`timescale 1ns / 1ps

module booth_radix2_multiplier_core
  import brm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic signed [InW-1:0]   multiplicand_i,
  input  logic signed [InW-1:0]   multiplier_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [ProdW-1:0] product_o
);

  logic  valid_w [Width+1];
  logic  stall_w [Width+1];
  step_t state_w [Width+1];

  assign valid_w[0] = in_valid_i;
  assign state_w[0] = load_step(multiplicand_i, multiplier_i);
  assign in_stall_o = stall_w[0];

  for (genvar k = 0; k < Width; k++) begin : g_cell
    brm_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_w[k]),
      .state_i (state_w[k]),
      .stall_o (stall_w[k]),
      .valid_o (valid_w[k+1]),
      .state_o (state_w[k+1]),
      .stall_i (stall_w[k+1])
    );
  end

  assign stall_w[Width] = out_stall_i;
  assign out_valid_o    = valid_w[Width];
  assign product_o      = get_product(state_w[Width]);

endmodule
